// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the execute block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define MSIE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MSIE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSIE_ASSERT(lbl, prop, msg)
`define MSIE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/msie_pkg.sv =====
// Package with constants, opcodes and shared types of the execute block.
package msie_pkg;

	localparam int XLEN          = 32;
	localparam int RF_DEPTH      = 32;
	localparam int RF_AW         = $clog2(RF_DEPTH);
	localparam int PROGRAM_DEPTH = 1024;
	localparam int PC_W          = $clog2(PROGRAM_DEPTH);
	localparam int PLEN_W        = 11;
	localparam int TGT_W         = ((PC_W > 16) ? PC_W : 16) + 2;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_MUL     = 6'h1C;

	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	localparam logic [RF_AW-1:0] REG_ZERO = RF_AW'(0);
	localparam logic [RF_AW-1:0] REG_V0   = RF_AW'(2);
	localparam logic [RF_AW-1:0] REG_A0   = RF_AW'(4);

	localparam logic [XLEN-1:0] SYS_CODE_INT  = XLEN'(1);
	localparam logic [XLEN-1:0] SYS_CODE_CHAR = XLEN'(11);

	typedef struct packed {
		logic              en;
		logic [RF_AW-1:0]  addr;
		logic [XLEN-1:0]   data;
		logic              pin;
		logic [XLEN-1:0]   pin_code;
		logic [XLEN-1:0]   pin_val;
	} msie_wb_t;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              sys_valid;
		logic [XLEN-1:0]   sys_code;
		logic [XLEN-1:0]   sys_value;
		logic              ended;
		logic              illegal;
	} msie_res_t;

endpackage

// ===== rtl/msie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/msie_regfile.sv =====
// Register file with reset valid bits, write forwarding and pinned $2 and $4.
module msie_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [msie_pkg::RF_AW-1:0]    rs_addr,
	input  logic [msie_pkg::RF_AW-1:0]    rt_addr,
	input  logic                          commit,
	input  msie_pkg::msie_wb_t            wb,
	output logic [msie_pkg::XLEN-1:0]     rs_data,
	output logic [msie_pkg::XLEN-1:0]     rt_data,
	output logic [msie_pkg::XLEN-1:0]     v0_data,
	output logic [msie_pkg::XLEN-1:0]     a0_data
);
	import msie_pkg::*;

	logic [RF_DEPTH-1:0] vld_q;
	logic [RF_AW-1:0]    rs_s1;
	logic [RF_AW-1:0]    rt_s1;
	logic                fwd_rs_s1;
	logic                fwd_rt_s1;
	logic [XLEN-1:0]     fwd_data_s1;
	logic [XLEN-1:0]     ram_rs;
	logic [XLEN-1:0]     ram_rt;
	logic [XLEN-1:0]     v0_q;
	logic [XLEN-1:0]     a0_q;
	logic                wr_fire;

	function automatic logic [XLEN-1:0] pick(
		input logic [RF_AW-1:0] idx,
		input logic             fwd,
		input logic             valid,
		input logic [XLEN-1:0]  ram,
		input logic [XLEN-1:0]  fwd_data,
		input logic [XLEN-1:0]  v0,
		input logic [XLEN-1:0]  a0
	);
		logic [XLEN-1:0] val;
		case (idx)
			REG_ZERO: val = '0;
			REG_V0:   val = v0;
			REG_A0:   val = a0;
			default: begin
				if (fwd) begin
					val = fwd_data;
				end else if (valid) begin
					val = ram;
				end else begin
					val = '0;
				end
			end
		endcase
		return val;
	endfunction

	assign wr_fire = commit & wb.en;

	msie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_rs (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (wb.addr),
		.wdata (wb.data),
		.re    (rd_en),
		.raddr (rs_addr),
		.rdata (ram_rs)
	);

	msie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_rt (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (wb.addr),
		.wdata (wb.data),
		.re    (rd_en),
		.raddr (rt_addr),
		.rdata (ram_rt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_fire) begin
			vld_q[wb.addr] <= 1'b1;
		end
	end

	// A write that retires in the same cycle as the read is taken from the write port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rs_s1       <= rs_addr;
			rt_s1       <= rt_addr;
			fwd_rs_s1   <= wr_fire && (wb.addr == rs_addr);
			fwd_rt_s1   <= wr_fire && (wb.addr == rt_addr);
			fwd_data_s1 <= wb.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= '0;
			a0_q <= '0;
		end else if (commit) begin
			if (wb.pin) begin
				v0_q <= wb.pin_code;
				a0_q <= wb.pin_val;
			end else begin
				if (wb.en && (wb.addr == REG_V0)) begin
					v0_q <= wb.data;
				end
				if (wb.en && (wb.addr == REG_A0)) begin
					a0_q <= wb.data;
				end
			end
		end
	end

	assign rs_data = pick(rs_s1, fwd_rs_s1, vld_q[rs_s1], ram_rs, fwd_data_s1, v0_q, a0_q);
	assign rt_data = pick(rt_s1, fwd_rt_s1, vld_q[rt_s1], ram_rt, fwd_data_s1, v0_q, a0_q);
	assign v0_data = v0_q;
	assign a0_data = a0_q;

endmodule

// ===== rtl/msie_exec.sv =====
// Decode and execute logic for one instruction word.
module msie_exec (
	input  logic [31:0]                   instr,
	input  logic [msie_pkg::PC_W-1:0]     pc,
	input  logic                          stopped,
	input  logic [msie_pkg::XLEN-1:0]     pinned_code,
	input  logic [msie_pkg::XLEN-1:0]     pinned_value,
	input  logic [msie_pkg::PLEN_W-1:0]   prog_len,
	input  logic [msie_pkg::XLEN-1:0]     rs_val,
	input  logic [msie_pkg::XLEN-1:0]     rt_val,
	input  logic [msie_pkg::XLEN-1:0]     v0_val,
	input  logic [msie_pkg::XLEN-1:0]     a0_val,
	output msie_pkg::msie_wb_t            wb,
	output logic                          stopped_next,
	output msie_pkg::msie_res_t           res
);
	import msie_pkg::*;

	logic [5:0]        op;
	logic [5:0]        fn;
	logic [RF_AW-1:0]  rt;
	logic [RF_AW-1:0]  rd;
	logic [15:0]       imm;
	logic [XLEN-1:0]   simm;
	logic [XLEN-1:0]   mul_res;
	logic              illegal;
	logic              is_sys;
	logic              taken;
	logic              wr_en;
	logic [RF_AW-1:0]  wr_addr;
	logic [XLEN-1:0]   wr_data;
	logic              emit;
	logic              stop_code;
	logic              neg;
	logic [TGT_W-1:0]  pc_ext;
	logic [TGT_W-1:0]  off_ext;
	logic [TGT_W-1:0]  tgt;
	logic [PC_W-1:0]   next_pc_c;

	assign op      = instr[31:26];
	assign fn      = instr[5:0];
	assign rt      = instr[20:16];
	assign rd      = instr[15:11];
	assign imm     = instr[15:0];
	assign simm    = {{(XLEN-16){imm[15]}}, imm};
	assign mul_res = rs_val * rt_val;

	always_comb begin
		illegal = 1'b0;
		is_sys  = 1'b0;
		taken   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = rd;
		wr_data = '0;
		case (op)
			OP_SPECIAL: begin
				wr_en = 1'b1;
				case (fn)
					FN_SYSCALL: begin
						wr_en  = 1'b0;
						is_sys = 1'b1;
					end
					FN_ADD: wr_data = rs_val + rt_val;
					FN_SUB: wr_data = rs_val - rt_val;
					FN_AND: wr_data = rs_val & rt_val;
					FN_OR:  wr_data = rs_val | rt_val;
					FN_SLT: wr_data = XLEN'($signed(rs_val) < $signed(rt_val));
					default: begin
						wr_en   = 1'b0;
						illegal = 1'b1;
					end
				endcase
			end
			OP_MUL: begin
				wr_en   = 1'b1;
				wr_data = mul_res;
			end
			OP_BEQ, OP_BNE: begin
				taken = (op == OP_BEQ) == (rs_val == rt_val);
			end
			OP_ADDI: begin
				wr_en   = 1'b1;
				wr_addr = rt;
				wr_data = rs_val + simm;
			end
			OP_SLTI: begin
				wr_en   = 1'b1;
				wr_addr = rt;
				wr_data = XLEN'($signed(rs_val) < $signed(simm));
			end
			OP_ANDI: begin
				wr_en   = 1'b1;
				wr_addr = rt;
				wr_data = rs_val & simm;
			end
			OP_ORI: begin
				wr_en   = 1'b1;
				wr_addr = rt;
				wr_data = rs_val | simm;
			end
			OP_LUI: begin
				wr_en   = 1'b1;
				wr_addr = rt;
				wr_data = {imm, 16'h0000};
			end
			default: illegal = 1'b1;
		endcase
	end

	assign emit      = is_sys & ~stopped;
	assign stop_code = (v0_val != SYS_CODE_INT) && (v0_val != SYS_CODE_CHAR);

	assign pc_ext  = {{(TGT_W-PC_W){1'b0}}, pc};
	assign off_ext = {{(TGT_W-16){imm[15]}}, imm};
	assign tgt     = taken ? (pc_ext + off_ext) : (pc_ext + TGT_W'(1));
	assign neg     = tgt[TGT_W-1];

	assign stopped_next = stopped | (is_sys & stop_code) | neg;

	assign wb.en       = wr_en && (wr_addr != REG_ZERO);
	assign wb.addr     = wr_addr;
	assign wb.data     = wr_data;
	assign wb.pin      = stopped_next;
	assign wb.pin_code = emit ? v0_val : pinned_code;
	assign wb.pin_val  = emit ? a0_val : pinned_value;

	always_comb begin
		if (neg) begin
			next_pc_c = '0;
		end else if (tgt > TGT_W'(PROGRAM_DEPTH - 1)) begin
			next_pc_c = PC_W'(PROGRAM_DEPTH - 1);
		end else begin
			next_pc_c = tgt[PC_W-1:0];
		end
	end

	assign res.next_pc   = next_pc_c;
	assign res.sys_valid = emit;
	assign res.sys_code  = emit ? v0_val : '0;
	assign res.sys_value = emit ? a0_val : '0;
	assign res.ended     = neg || (tgt >= {{(TGT_W-PLEN_W){1'b0}}, prog_len});
	assign res.illegal   = illegal;

endmodule

// ===== rtl/mips_subset_instruction_execute.sv =====
// Top level of the MIPS integer subset executor.
// The input channel takes one 32-bit instruction word per transaction, fetched by the
// user at the program counter that the previous result reported in next_pc.
// The output channel returns one result per instruction: next_pc, the syscall
// event with $2 and $4, the ended flag and the illegal flag.
// The configuration channel writes program_length; it is always ready. The user must
// write it only while no instruction is in flight; the block does not enforce this.
// An accepted instruction reads its operands in the cycle of acceptance, executes
// in the next cycle and lands in the output register once that register can advance.
// Throughput is one instruction per cycle unless the receiver stalls; the register
// file read, the 32-bit multiply and the forwarded write back set that figure.
// When the receiver stalls, the output register holds its result and one more
// instruction waits in the execute stage; in_ready drops only when both are full.
// Reset clears the register file valid bits, the program counter, the stop state,
// the pinned syscall pair, program_length and both pipeline valids.
module mips_subset_instruction_execute (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       instruction_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [msie_pkg::PC_W-1:0]         next_pc,
	output logic                              syscall_valid,
	output logic signed [31:0]                syscall_code,
	output logic signed [31:0]                syscall_value,
	output logic                              ended,
	output logic                              illegal,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [msie_pkg::PLEN_W-1:0]       cfg_data
);
	import msie_pkg::*;

	`include "assert_macros.svh"

	logic              in_fire;
	logic              out_adv;
	logic              s1_fire;
	logic              vld_s1;
	logic [31:0]       instr_s1;
	logic [PC_W-1:0]   pc_q;
	logic              stopped_q;
	logic [XLEN-1:0]   pinned_code_q;
	logic [XLEN-1:0]   pinned_value_q;
	logic [PLEN_W-1:0] prog_len_q;
	logic [XLEN-1:0]   rs_data;
	logic [XLEN-1:0]   rt_data;
	logic [XLEN-1:0]   v0_data;
	logic [XLEN-1:0]   a0_data;
	msie_wb_t          wb;
	logic              stopped_next;
	msie_res_t         res;
	msie_res_t         res_q;
	logic              out_vld_q;

	assign out_adv  = ~out_vld_q | out_ready;
	assign s1_fire  = vld_s1 & out_adv;
	assign in_ready = ~vld_s1 | out_adv;
	assign in_fire  = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			prog_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1 <= instruction_word;
		end
	end

	msie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rs_addr (instruction_word[25:21]),
		.rt_addr (instruction_word[20:16]),
		.commit  (s1_fire),
		.wb      (wb),
		.rs_data (rs_data),
		.rt_data (rt_data),
		.v0_data (v0_data),
		.a0_data (a0_data)
	);

	msie_exec u_exec (
		.instr        (instr_s1),
		.pc           (pc_q),
		.stopped      (stopped_q),
		.pinned_code  (pinned_code_q),
		.pinned_value (pinned_value_q),
		.prog_len     (prog_len_q),
		.rs_val       (rs_data),
		.rt_val       (rt_data),
		.v0_val       (v0_data),
		.a0_val       (a0_data),
		.wb           (wb),
		.stopped_next (stopped_next),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= '0;
			stopped_q      <= 1'b0;
			pinned_code_q  <= '0;
			pinned_value_q <= '0;
		end else if (s1_fire) begin
			pc_q           <= res.next_pc;
			stopped_q      <= stopped_next;
			pinned_code_q  <= wb.pin_code;
			pinned_value_q <= wb.pin_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_vld_q;
	assign next_pc       = res_q.next_pc;
	assign syscall_valid = res_q.sys_valid;
	assign syscall_code  = $signed(res_q.sys_code);
	assign syscall_value = $signed(res_q.sys_value);
	assign ended         = res_q.ended;
	assign illegal       = res_q.illegal;

	`MSIE_ASSERT(a_exec_fills_out, s1_fire |=> out_vld_q, "Executed instruction did not reach the output register.")
	`MSIE_ASSERT(a_stall_holds_s1, (vld_s1 && !out_adv) |=> (vld_s1 && $stable(instr_s1)), "Execute stage lost its instruction during a stall.")
	`MSIE_ASSERT(a_sys_only_running, (s1_fire && res.sys_valid) |-> !stopped_q, "Syscall event reported after the block stopped.")
	`MSIE_ASSERT(a_pinned_pair, stopped_q |-> ((v0_data == pinned_code_q) && (a0_data == pinned_value_q)), "Registers $2 and $4 differ from the pinned pair after stop.")
	`MSIE_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!vld_s1 && !out_vld_q && !stopped_q), "Pipeline or stop state not cleared by reset.")

endmodule
